FILE: design/ivs_pkg.sv
// shared types and constants of the irrigation valve sequencer
package ivs_pkg;

  // valve bank
  localparam int unsigned VALVE_COUNT = 5;

  // schedule slots
  localparam int unsigned SLOT_REGS  = 4;
  localparam int unsigned SLOT_COUNT = 4;
  localparam int unsigned SLOT_LIMIT = (SLOT_COUNT < SLOT_REGS) ? SLOT_COUNT : SLOT_REGS;

  // timing and window terms
  localparam int unsigned MS_PER_S      = 1000;
  localparam int unsigned DUR_WIN_MULT  = 5;
  localparam int unsigned WATCHDOG_MULT = 2;

  // configuration port
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // register indexes
  localparam logic [2:0] REG_DURATION   = 3'd0;
  localparam logic [2:0] REG_INTERVAL   = 3'd1;
  localparam logic [2:0] REG_SLOT_0     = 3'd2;
  localparam logic [2:0] REG_SLOT_1     = 3'd3;
  localparam logic [2:0] REG_SLOT_2     = 3'd4;
  localparam logic [2:0] REG_SLOT_3     = 3'd5;
  localparam logic [2:0] REG_SLOT_COUNT = 3'd6;

  // register reset values
  localparam logic [15:0] DURATION_RST   = 16'd300;
  localparam logic [15:0] INTERVAL_RST   = 16'd30;
  localparam logic [10:0] SLOT_0_RST     = 11'(7 * 60);
  localparam logic [10:0] SLOT_1_RST     = 11'(17 * 60);
  localparam logic [10:0] SLOT_2_RST     = 11'd0;
  localparam logic [10:0] SLOT_3_RST     = 11'd0;
  localparam logic [2:0]  SLOT_COUNT_RST = 3'd2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  valve_index;
    logic [31:0] now_ms;
    logic [10:0] minute_of_day;
    logic [2:0]  weekday;
    logic [4:0]  moisture_wet;
  } item_t;

  typedef struct packed {
    logic [4:0] valve_open_mask;
    logic       in_watering_window;
    logic       sequence_running;
    logic [2:0] active_valve;
    logic       watchdog_fired;
  } result_t;

  typedef struct packed {
    logic [15:0]                watering_duration_s;
    logic [15:0]                interval_term;
    logic [SLOT_REGS-1:0][10:0] slot_time;
    logic [2:0]                 slot_count;
  } cfg_t;

endpackage

FILE: design/ivs_cfg.sv
// configuration register file with apb-style access
module ivs_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ivs_pkg::CFG_AW-1:0] paddr,
  input  logic [ivs_pkg::CFG_DW-1:0] pwdata,
  output logic [ivs_pkg::CFG_DW-1:0] prdata,
  output logic                      pready,
  output ivs_pkg::cfg_t             cfg_o
);

  ivs_pkg::cfg_t cfg_q;
  logic [2:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.watering_duration_s <= ivs_pkg::DURATION_RST;
      cfg_q.interval_term       <= ivs_pkg::INTERVAL_RST;
      cfg_q.slot_time[0]        <= ivs_pkg::SLOT_0_RST;
      cfg_q.slot_time[1]        <= ivs_pkg::SLOT_1_RST;
      cfg_q.slot_time[2]        <= ivs_pkg::SLOT_2_RST;
      cfg_q.slot_time[3]        <= ivs_pkg::SLOT_3_RST;
      cfg_q.slot_count          <= ivs_pkg::SLOT_COUNT_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        ivs_pkg::REG_DURATION:   cfg_q.watering_duration_s <= pwdata[15:0];
        ivs_pkg::REG_INTERVAL:   cfg_q.interval_term       <= pwdata[15:0];
        ivs_pkg::REG_SLOT_0:     cfg_q.slot_time[0]        <= pwdata[10:0];
        ivs_pkg::REG_SLOT_1:     cfg_q.slot_time[1]        <= pwdata[10:0];
        ivs_pkg::REG_SLOT_2:     cfg_q.slot_time[2]        <= pwdata[10:0];
        ivs_pkg::REG_SLOT_3:     cfg_q.slot_time[3]        <= pwdata[10:0];
        ivs_pkg::REG_SLOT_COUNT: cfg_q.slot_count          <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ivs_pkg::REG_DURATION:   prdata = 32'(cfg_q.watering_duration_s);
      ivs_pkg::REG_INTERVAL:   prdata = 32'(cfg_q.interval_term);
      ivs_pkg::REG_SLOT_0:     prdata = 32'(cfg_q.slot_time[0]);
      ivs_pkg::REG_SLOT_1:     prdata = 32'(cfg_q.slot_time[1]);
      ivs_pkg::REG_SLOT_2:     prdata = 32'(cfg_q.slot_time[2]);
      ivs_pkg::REG_SLOT_3:     prdata = 32'(cfg_q.slot_time[3]);
      ivs_pkg::REG_SLOT_COUNT: prdata = 32'(cfg_q.slot_count);
      default:                 prdata = '0;
    endcase
  end

endmodule

FILE: design/ivs_core.sv
// sequencer state registers and single-pass next-state logic
module ivs_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  ivs_pkg::item_t   item_i,
  input  ivs_pkg::cfg_t    cfg_i,
  output ivs_pkg::result_t result_o
);

  localparam int unsigned VW = ivs_pkg::VALVE_COUNT;
  localparam int unsigned SW = $clog2(ivs_pkg::VALVE_COUNT + 1);

  logic [VW-1:0] valve_open_q, valve_open_d;
  logic          window_q, window_d;
  logic          running_q, running_d;
  logic [SW-1:0] seq_q, seq_d;
  logic [31:0]   start_q, start_d;
  logic [2:0]    sday_q, sday_d;
  logic [10:0]   sslot_q, sslot_d;
  logic [10:0]   aslot_q, aslot_d;
  logic          fired;

  logic [2:0]    n_slots;
  logic [31:0]   win_span;
  logic [31:0]   dur_ms;
  logic [31:0]   dog_ms;
  logic [VW-1:0] wet;

  function automatic logic [VW-1:0] vbit(input int unsigned idx);
    logic [VW-1:0] b;
    b = '0;
    if (idx < ivs_pkg::VALVE_COUNT) begin
      b = VW'(1) << idx;
    end
    return b;
  endfunction

  assign n_slots = (32'(cfg_i.slot_count) > ivs_pkg::SLOT_LIMIT)
                   ? 3'(ivs_pkg::SLOT_LIMIT) : cfg_i.slot_count;
  assign win_span = 32'(cfg_i.watering_duration_s) * 32'(ivs_pkg::DUR_WIN_MULT)
                  + 32'(cfg_i.interval_term) * 32'(ivs_pkg::VALVE_COUNT);
  assign dur_ms = 32'(cfg_i.watering_duration_s) * 32'(ivs_pkg::MS_PER_S);
  assign dog_ms = 32'(cfg_i.watering_duration_s)
                * 32'(ivs_pkg::MS_PER_S * ivs_pkg::WATCHDOG_MULT);
  assign wet    = VW'(item_i.moisture_wet);

  always_comb begin
    valve_open_d = valve_open_q;
    window_d     = window_q;
    running_d    = running_q;
    seq_d        = seq_q;
    start_d      = start_q;
    sday_d       = sday_q;
    sslot_d      = sslot_q;
    aslot_d      = aslot_q;
    fired        = 1'b0;

    unique case (item_i.opcode)
      ivs_pkg::OP_TICK: begin
        valve_open_d = valve_open_d & ~wet;

        // schedule search, highest matching slot wins
        if (!window_q) begin
          for (int i = 0; i < ivs_pkg::SLOT_REGS; i++) begin
            if ((i < 32'(n_slots)) &&
                (item_i.minute_of_day >= cfg_i.slot_time[i]) &&
                (32'(item_i.minute_of_day) <= 32'(cfg_i.slot_time[i]) + win_span) &&
                ((sday_q != item_i.weekday) || (sslot_q != cfg_i.slot_time[i]))) begin
              window_d = 1'b1;
              aslot_d  = cfg_i.slot_time[i];
            end
          end
        end

        if (window_d && !running_q) begin
          running_d    = 1'b1;
          seq_d        = '0;
          valve_open_d = valve_open_d | vbit(0);
          start_d      = item_i.now_ms;
        end else if (window_d && running_q) begin
          if ((item_i.now_ms - start_q) > dur_ms) begin
            valve_open_d = valve_open_d & ~vbit(32'(seq_q));
            seq_d        = seq_q + SW'(1);
            if (32'(seq_d) >= ivs_pkg::VALVE_COUNT) begin
              running_d = 1'b0;
              window_d  = 1'b0;
              sday_d    = item_i.weekday;
              sslot_d   = aslot_d;
            end else begin
              valve_open_d = valve_open_d | vbit(32'(seq_d));
              start_d      = item_i.now_ms;
            end
          end
        end else if (!window_d && running_q) begin
          valve_open_d = valve_open_d & ~vbit(32'(seq_q));
          running_d    = 1'b0;
        end

        // overtime watchdog
        if (running_d && ((item_i.now_ms - start_d) > dog_ms)) begin
          valve_open_d = '0;
          sday_d       = item_i.weekday;
          sslot_d      = aslot_d;
          window_d     = 1'b0;
          running_d    = 1'b0;
          fired        = 1'b1;
        end
      end
      ivs_pkg::OP_OPEN:  valve_open_d = valve_open_q | vbit(32'(item_i.valve_index));
      ivs_pkg::OP_CLOSE: valve_open_d = valve_open_q & ~vbit(32'(item_i.valve_index));
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valve_open_q <= '0;
      window_q     <= 1'b0;
      running_q    <= 1'b0;
      seq_q        <= '0;
      start_q      <= '0;
      sday_q       <= '0;
      sslot_q      <= '0;
      aslot_q      <= '0;
    end else if (en_i) begin
      valve_open_q <= valve_open_d;
      window_q     <= window_d;
      running_q    <= running_d;
      seq_q        <= seq_d;
      start_q      <= start_d;
      sday_q       <= sday_d;
      sslot_q      <= sslot_d;
      aslot_q      <= aslot_d;
    end
  end

  assign result_o.valve_open_mask    = 5'(valve_open_d);
  assign result_o.in_watering_window = window_d;
  assign result_o.sequence_running   = running_d;
  assign result_o.active_valve       = 3'(seq_d);
  assign result_o.watchdog_fired     = fired;

endmodule

FILE: design/irrigation_valve_sequencer.sv
// top level of the irrigation valve sequencer
//
// input channel (in_valid_i, in_ready_o, in_data_i) carries one transaction per
// tick or manual valve command; output channel (out_valid_o, out_ready_i,
// out_data_o) returns exactly one result transaction per input transaction,
// in order. configuration sits on the apb-style port, one register per word
// at byte address 4*index; pready is always high and writes take effect at
// the access cycle. write configuration only while no transaction is in flight.
// a transaction accepted at one edge is captured in the input register; the
// step logic runs against the state registers and the result is loaded into
// the output register once it is empty or being read, then shows on
// out_valid_o. throughput is one transaction per cycle while the receiver
// does not stall, set by the single input-register to output-register pass.
// when the receiver stalls, the result holds in the output register and one
// more transaction waits in the input register; in_ready_o then drops.
// reset clears all valves, flags, served-slot records and the valid bits of
// both registers, and loads the configuration defaults.
module irrigation_valve_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  ivs_pkg::item_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output ivs_pkg::result_t           out_data_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ivs_pkg::CFG_AW-1:0] paddr,
  input  logic [ivs_pkg::CFG_DW-1:0] pwdata,
  output logic [ivs_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  ivs_pkg::cfg_t    cfg;
  ivs_pkg::item_t   item_q;
  ivs_pkg::result_t result;
  ivs_pkg::result_t out_data_q;
  logic             item_valid_q;
  logic             out_valid_q;
  logic             advance;
  logic             in_fire;

  ivs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ivs_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign advance    = item_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !item_valid_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (in_fire) begin
      item_valid_q <= 1'b1;
    end else if (advance) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: design/ivs_checker.sv
// port-level checks for the irrigation valve sequencer and their bind
module ivs_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input ivs_pkg::result_t out_data_o
);

  // a stalled result transaction stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result transaction changed while stalled");

  // an accepted input, when the output was free, yields a result through the input and output registers
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> ##1 out_valid_o)
    else $error("result missing after accepted transaction");

  // a running sequence always lies inside a watering window
  a_run_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.sequence_running |-> out_data_o.in_watering_window)
    else $error("sequence running outside a watering window");

  // watchdog leaves everything closed and idle
  a_watchdog_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.watchdog_fired |->
      out_data_o.valve_open_mask == 5'd0 && !out_data_o.sequence_running &&
      !out_data_o.in_watering_window)
    else $error("watchdog left valves open or sequence active");

endmodule

bind irrigation_valve_sequencer ivs_checker u_ivs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

FILE: test/irrigation_valve_sequencer_test.sv
// self-checking testbench of the irrigation valve sequencer: directed table, then random phases
module irrigation_valve_sequencer_test;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned PHASES = 6;
  localparam int unsigned ITEMS_PER_PHASE = 115;
  localparam logic [1:0] OP_SPARE = 2'd3;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  ivs_pkg::item_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  ivs_pkg::result_t out_data_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ivs_pkg::CFG_AW-1:0] paddr = '0;
  logic [ivs_pkg::CFG_DW-1:0] pwdata = '0;
  logic [ivs_pkg::CFG_DW-1:0] prdata;
  logic pready;

  // predicted valve state and configuration
  logic [4:0] valves_open = '0;
  logic window_on = 1'b0;
  logic seq_on = 1'b0;
  logic [2:0] seq_valve = '0;
  logic [31:0] valve_since = '0;
  logic [2:0] served_weekday = '0;
  logic [10:0] served_slot = '0;
  logic [10:0] window_slot = '0;
  logic [15:0] duration_s = ivs_pkg::DURATION_RST;
  logic [15:0] interval = ivs_pkg::INTERVAL_RST;
  logic [10:0] slot_start [ivs_pkg::SLOT_REGS] = '{ivs_pkg::SLOT_0_RST, ivs_pkg::SLOT_1_RST,
                                                    ivs_pkg::SLOT_2_RST, ivs_pkg::SLOT_3_RST};
  logic [2:0] slots_used = ivs_pkg::SLOT_COUNT_RST;

  ivs_pkg::result_t valve_reports_due [$];
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_pct = 0;
  int unsigned stall_pct = 0;

  ivs_pkg::item_t table_items [$];
  bit table_typed [$];
  ivs_pkg::result_t table_results [$];

  irrigation_valve_sequencer i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i(in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o(out_data_o),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #1 clk_i = ~clk_i;

  function automatic logic [4:0] valve_mask(logic [2:0] v);
    return (v < ivs_pkg::VALVE_COUNT) ? 5'(1 << v) : 5'd0;
  endfunction

  function automatic ivs_pkg::item_t mk_tick(int unsigned now, int unsigned minute,
                                             int unsigned day, int unsigned wet);
    ivs_pkg::item_t it;
    it.opcode = ivs_pkg::OP_TICK;
    it.valve_index = 3'd0;
    it.now_ms = now;
    it.minute_of_day = 11'(minute);
    it.weekday = 3'(day);
    it.moisture_wet = 5'(wet);
    return it;
  endfunction

  function automatic ivs_pkg::item_t mk_cmd(logic [1:0] op, int unsigned valve);
    ivs_pkg::item_t it;
    it.opcode = op;
    it.valve_index = 3'(valve);
    it.now_ms = 32'hFFFF_FFFF;
    it.minute_of_day = 11'd1439;
    it.weekday = 3'd6;
    it.moisture_wet = 5'h1F;
    return it;
  endfunction

  function automatic ivs_pkg::result_t mk_res(int unsigned mask, bit win, bit run,
                                              int unsigned act);
    ivs_pkg::result_t r;
    r.valve_open_mask = 5'(mask);
    r.in_watering_window = win;
    r.sequence_running = run;
    r.active_valve = 3'(act);
    r.watchdog_fired = 1'b0;
    return r;
  endfunction

  task automatic add_row(input ivs_pkg::item_t it, input bit typed,
                         input ivs_pkg::result_t res);
    table_items.push_back(it);
    table_typed.push_back(typed);
    table_results.push_back(res);
  endtask

  task automatic predict_valves(input ivs_pkg::item_t it, output ivs_pkg::result_t r);
    int unsigned n;
    int unsigned hi;
    logic [31:0] dur_ms;
    logic [31:0] elapsed;
    bit fired;
    fired = 1'b0;
    case (it.opcode)
      ivs_pkg::OP_TICK: begin
        valves_open &= ~it.moisture_wet;
        if (!window_on) begin
          n = (slots_used > ivs_pkg::SLOT_LIMIT) ? ivs_pkg::SLOT_LIMIT : slots_used;
          for (int unsigned i = 0; i < n; i++) begin
            hi = slot_start[i] + duration_s * ivs_pkg::DUR_WIN_MULT
               + interval * ivs_pkg::VALVE_COUNT;
            if (it.minute_of_day >= slot_start[i] && it.minute_of_day <= hi &&
                (served_weekday != it.weekday || served_slot != slot_start[i])) begin
              window_on = 1'b1;
              window_slot = slot_start[i];
            end
          end
        end
        dur_ms = duration_s * ivs_pkg::MS_PER_S;
        elapsed = it.now_ms - valve_since;
        if (window_on && !seq_on) begin
          seq_on = 1'b1;
          seq_valve = 3'd0;
          valves_open |= valve_mask(3'd0);
          valve_since = it.now_ms;
        end else if (window_on && seq_on) begin
          if (elapsed > dur_ms) begin
            valves_open &= ~valve_mask(seq_valve);
            seq_valve = seq_valve + 3'd1;
            if (seq_valve >= ivs_pkg::VALVE_COUNT) begin
              seq_on = 1'b0;
              window_on = 1'b0;
              served_weekday = it.weekday;
              served_slot = window_slot;
            end else begin
              valves_open |= valve_mask(seq_valve);
              valve_since = it.now_ms;
            end
          end
        end else if (!window_on && seq_on) begin
          valves_open &= ~valve_mask(seq_valve);
          seq_on = 1'b0;
        end
        elapsed = it.now_ms - valve_since;
        if (seq_on && elapsed > dur_ms * ivs_pkg::WATCHDOG_MULT) begin
          valves_open = '0;
          served_weekday = it.weekday;
          served_slot = window_slot;
          window_on = 1'b0;
          seq_on = 1'b0;
          fired = 1'b1;
        end
      end
      ivs_pkg::OP_OPEN: valves_open |= valve_mask(it.valve_index);
      ivs_pkg::OP_CLOSE: valves_open &= ~valve_mask(it.valve_index);
      default: ;
    endcase
    r.valve_open_mask = valves_open;
    r.in_watering_window = window_on;
    r.sequence_running = seq_on;
    r.active_valve = seq_valve;
    r.watchdog_fired = fired;
  endtask

  task automatic push_item(input ivs_pkg::item_t it, input bit typed,
                           input ivs_pkg::result_t typed_res);
    ivs_pkg::result_t pred;
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    predict_valves(it, pred);
    valve_reports_due.push_back(typed ? typed_res : pred);
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
    case (idx)
      ivs_pkg::REG_DURATION: duration_s = val[15:0];
      ivs_pkg::REG_INTERVAL: interval = val[15:0];
      ivs_pkg::REG_SLOT_0: slot_start[0] = val[10:0];
      ivs_pkg::REG_SLOT_1: slot_start[1] = val[10:0];
      ivs_pkg::REG_SLOT_2: slot_start[2] = val[10:0];
      ivs_pkg::REG_SLOT_3: slot_start[3] = val[10:0];
      ivs_pkg::REG_SLOT_COUNT: slots_used = val[2:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int unsigned dur, input int unsigned intv,
                                input int unsigned s0, input int unsigned s1,
                                input int unsigned s2, input int unsigned s3,
                                input int unsigned cnt);
    reg_write(ivs_pkg::REG_DURATION, dur);
    reg_write(ivs_pkg::REG_INTERVAL, intv);
    reg_write(ivs_pkg::REG_SLOT_0, s0);
    reg_write(ivs_pkg::REG_SLOT_1, s1);
    reg_write(ivs_pkg::REG_SLOT_2, s2);
    reg_write(ivs_pkg::REG_SLOT_3, s3);
    reg_write(ivs_pkg::REG_SLOT_COUNT, cnt);
  endtask

  task automatic flag(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin : result_check
    ivs_pkg::result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (valve_reports_due.size() == 0) begin
        flag($sformatf("result %h with no transaction pending", out_data_o));
      end else begin
        want = valve_reports_due.pop_front();
        if (out_data_o.valve_open_mask !== want.valve_open_mask)
          flag($sformatf("valve_open_mask %b, want %b", out_data_o.valve_open_mask,
                         want.valve_open_mask));
        if (out_data_o.in_watering_window !== want.in_watering_window)
          flag($sformatf("in_watering_window %b, want %b", out_data_o.in_watering_window,
                         want.in_watering_window));
        if (out_data_o.sequence_running !== want.sequence_running)
          flag($sformatf("sequence_running %b, want %b", out_data_o.sequence_running,
                         want.sequence_running));
        if (out_data_o.active_valve !== want.active_valve)
          flag($sformatf("active_valve %0d, want %0d", out_data_o.active_valve,
                         want.active_valve));
        if (out_data_o.watchdog_fired !== want.watchdog_fired)
          flag($sformatf("watchdog_fired %b, want %b", out_data_o.watchdog_fired,
                         want.watchdog_fired));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("irrigation_valve_sequencer_test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    ivs_pkg::item_t it;
    logic [31:0] cur_now;
    int unsigned cur_day;
    int unsigned pick;
    int unsigned span;
    int mi;
    cur_now = '0;
    cur_day = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: slots at 420 and 1020, 300 s per valve
    add_row(mk_cmd(ivs_pkg::OP_OPEN, 0), 1'b1, mk_res(5'b00001, 0, 0, 0));
    add_row(mk_cmd(ivs_pkg::OP_OPEN, 4), 1'b1, mk_res(5'b10001, 0, 0, 0));
    add_row(mk_cmd(ivs_pkg::OP_OPEN, 7), 1'b1, mk_res(5'b10001, 0, 0, 0));
    add_row(mk_cmd(ivs_pkg::OP_CLOSE, 0), 1'b1, mk_res(5'b10000, 0, 0, 0));
    add_row(mk_cmd(OP_SPARE, 1), 1'b1, mk_res(5'b10000, 0, 0, 0));
    add_row(mk_cmd(ivs_pkg::OP_CLOSE, 5), 1'b1, mk_res(5'b10000, 0, 0, 0));
    add_row(mk_tick(0, 0, 0, 5'b11111), 1'b1, mk_res(5'b00000, 0, 0, 0));
    add_row(mk_cmd(ivs_pkg::OP_OPEN, 1), 1'b1, mk_res(5'b00010, 0, 0, 0));
    add_row(mk_tick(1000, 419, 6, 0), 1'b1, mk_res(5'b00010, 0, 0, 0));
    add_row(mk_tick(1000, 420, 0, 0), 1'b0, '0);
    add_row(mk_tick(301000, 425, 0, 5'b00010), 1'b0, '0);
    add_row(mk_tick(301001, 430, 0, 0), 1'b0, '0);
    add_row(mk_tick(32'hFFFF_FFFF, 1439, 0, 0), 1'b0, '0);
    add_row(mk_tick(300000, 1439, 0, 0), 1'b0, '0);
    add_row(mk_tick(600001, 0, 0, 0), 1'b0, '0);
    add_row(mk_tick(900002, 0, 0, 0), 1'b0, '0);
    add_row(mk_tick(900003, 500, 0, 0), 1'b0, '0);
    add_row(mk_tick(900004, 1020, 5, 0), 1'b0, '0);
    add_row(mk_cmd(ivs_pkg::OP_OPEN, 2), 1'b0, '0);
    add_row(mk_tick(900005, 1100, 5, 5'b10101), 1'b0, '0);
    add_row(mk_cmd(ivs_pkg::OP_CLOSE, 4), 1'b0, '0);
    for (int unsigned r = 0; r < table_items.size(); r++)
      push_item(table_items[r], table_typed[r], table_results[r]);
    in_valid_i <= 1'b0;

    for (int unsigned p = 0; p < PHASES; p++) begin
      while (valve_reports_due.size() != 0) @(posedge clk_i);
      @(posedge clk_i);
      case (p)
        0: apply_settings(2, 0, 0, 100, 700, 1439, 4);
        1: apply_settings(0, 0, 1439, 1439, 5, 5, 7);
        2: apply_settings(65535, 65535, 0, 1439, 720, 60, 1);
        3: apply_settings(1, 65535, $urandom_range(0, 1439), $urandom_range(0, 1439),
                          $urandom_range(0, 1439), $urandom_range(0, 1439), 5);
        4: apply_settings($urandom_range(0, 8), $urandom_range(0, 65535),
                          $urandom_range(0, 1439), $urandom_range(0, 1439),
                          $urandom_range(0, 1439), $urandom_range(0, 1439),
                          $urandom_range(0, 7));
        default: apply_settings(3, 1, $urandom_range(0, 1439), $urandom_range(0, 1439),
                                $urandom_range(0, 1439), $urandom_range(0, 1439), 0);
      endcase
      case (p % 4)
        0: begin
          gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          gap_pct = 62;
          stall_pct = 0;
        end
        2: begin
          gap_pct = 0;
          stall_pct = 62;
        end
        default: begin
          gap_pct = 13;
          stall_pct = 13;
        end
      endcase
      cur_day = $urandom_range(0, 6);
      for (int unsigned k = 0; k < ITEMS_PER_PHASE; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          pick = $urandom_range(0, 99);
          span = duration_s * 1500 + 2;
          if (pick < 5) cur_now = $urandom();
          else if (pick < 12) cur_now = cur_now + duration_s * 2000 + $urandom_range(1, 3);
          else cur_now = cur_now + $urandom_range(0, span);
          if ($urandom_range(0, 9) == 0) cur_day = $urandom_range(0, 6);
          if ($urandom_range(0, 9) < 6) begin
            mi = int'(slot_start[$urandom_range(0, 3)]) + int'($urandom_range(0, 34)) - 4;
            if (mi < 0) mi = 0;
            if (mi > 1439) mi = 1439;
          end else begin
            mi = int'($urandom_range(0, 1439));
          end
          it = mk_tick(cur_now, unsigned'(mi), cur_day,
                       ($urandom_range(0, 4) == 0) ? $urandom_range(0, 31) : 0);
        end else begin
          it.opcode = (pick < 85) ? ivs_pkg::OP_OPEN
                    : (pick < 97) ? ivs_pkg::OP_CLOSE : OP_SPARE;
          it.valve_index = ($urandom_range(0, 4) == 0) ? 3'($urandom_range(5, 7))
                                                       : 3'($urandom_range(0, 4));
          it.now_ms = $urandom();
          it.minute_of_day = 11'($urandom_range(0, 1439));
          it.weekday = 3'($urandom_range(0, 6));
          it.moisture_wet = 5'($urandom_range(0, 31));
        end
        push_item(it, 1'b0, '0);
      end
      in_valid_i <= 1'b0;
    end

    while (valve_reports_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("irrigation_valve_sequencer_test passed");
    end else begin
      $display("irrigation_valve_sequencer_test failed");
    end
    $finish;
  end

endmodule
